// ===== design/etk_pkg.sv =====
`timescale 1ns / 1ps

package etk_pkg;

    typedef enum logic [3:0] {
        KIND_IDENT  = 4'd0,
        KIND_NUMBER = 4'd1,
        KIND_ASSIGN = 4'd2,
        KIND_OPER   = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_COMMA  = 4'd6,
        KIND_LBRACE = 4'd7,
        KIND_RBRACE = 4'd8,
        KIND_END    = 4'd9,
        KIND_ERROR  = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        HOLD_NONE   = 2'd0,
        HOLD_IDENT  = 2'd1,
        HOLD_NUMBER = 2'd2
    } hold_t;

    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] token_char;
        logic       token_last;
        logic       run_last;
    } tok_item_t;

    // results caused by one input transaction: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } tok_pair_t;

endpackage

// ===== design/etk_lexer.sv =====
`timescale 1ns / 1ps

module etk_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  etk_pkg::src_item_t item,
    output etk_pkg::tok_pair_t pair
);
    import etk_pkg::*;

    logic [7:0] held_char_reg;
    logic [7:0] held_char_next;
    hold_t      held_kind_reg;
    hold_t      held_kind_next;
    logic       error_seen_reg;
    logic       error_seen_next;

    logic       held_valid;
    tok_item_t  held_tok;
    tok_item_t  single_tok;
    logic       is_letter;
    logic       is_digit;
    logic       is_space;
    logic       is_single;
    kind_t      single_kind;
    logic [7:0] c;

    assign c          = item.character;
    assign is_letter  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit   = (c >= 8'h30 && c <= 8'h39);
    assign is_space   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign held_valid = (held_kind_reg == HOLD_IDENT) || (held_kind_reg == HOLD_NUMBER);

    always_comb
    begin
        is_single   = 1'b1;
        single_kind = KIND_ERROR;
        case (c)
            CH_ASSIGN: single_kind = KIND_ASSIGN;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: single_kind = KIND_OPER;
            CH_LPAREN: single_kind = KIND_LPAREN;
            CH_RPAREN: single_kind = KIND_RPAREN;
            CH_COMMA:  single_kind = KIND_COMMA;
            CH_LBRACE: single_kind = KIND_LBRACE;
            CH_RBRACE: single_kind = KIND_RBRACE;
            default:   is_single = 1'b0;
        endcase
    end

    always_comb
    begin
        held_tok.token_kind = (held_kind_reg == HOLD_IDENT) ? KIND_IDENT : KIND_NUMBER;
        held_tok.token_char = held_char_reg;
        held_tok.token_last = 1'b1;
        held_tok.run_last   = 1'b0;

        single_tok.token_kind = is_single ? single_kind : KIND_ERROR;
        single_tok.token_char = c;
        single_tok.token_last = 1'b1;
        single_tok.run_last   = 1'b1;
    end

    always_comb
    begin
        held_char_next  = held_char_reg;
        held_kind_next  = held_kind_reg;
        error_seen_next = error_seen_reg;
        pair            = '0;

        if (item.end_of_input)
        begin
            pair.second.token_kind = KIND_END;
            pair.second.token_char = 8'h00;
            pair.second.token_last = 1'b1;
            pair.second.run_last   = 1'b1;
            if (!error_seen_reg && held_valid)
            begin
                pair.first = held_tok;
                pair.count = 2'd2;
            end
            else
            begin
                pair.first  = pair.second;
                pair.second = '0;
                pair.count  = 2'd1;
            end
            held_char_next  = 8'h00;
            held_kind_next  = HOLD_NONE;
            error_seen_next = 1'b0;
        end
        else if (error_seen_reg)
        begin
            pair.count = 2'd0;
        end
        else if (is_space)
        begin
            if (held_valid)
            begin
                pair.first          = held_tok;
                pair.first.run_last = 1'b1;
                pair.count          = 2'd1;
            end
            held_kind_next = HOLD_NONE;
        end
        else if (is_letter)
        begin
            if (held_valid)
            begin
                pair.first            = held_tok;
                pair.first.token_last = (held_kind_reg != HOLD_IDENT);
                pair.first.run_last   = 1'b1;
                pair.count            = 2'd1;
            end
            held_char_next = c;
            held_kind_next = HOLD_IDENT;
        end
        else if (is_digit)
        begin
            if (held_valid)
            begin
                pair.first            = held_tok;
                pair.first.token_last = 1'b0;
                pair.first.run_last   = 1'b1;
                pair.count            = 2'd1;
            end
            else
            begin
                held_kind_next = HOLD_NUMBER;
            end
            held_char_next = c;
        end
        else
        begin
            if (is_single && held_valid)
            begin
                pair.first  = held_tok;
                pair.second = single_tok;
                pair.count  = 2'd2;
            end
            else
            begin
                pair.first = single_tok;
                pair.count = 2'd1;
            end
            if (!is_single)
            begin
                error_seen_next = 1'b1;
            end
            held_kind_next = HOLD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg  <= 8'h00;
            held_kind_reg  <= HOLD_NONE;
            error_seen_reg <= 1'b0;
        end
        else if (take)
        begin
            held_char_reg  <= held_char_next;
            held_kind_reg  <= held_kind_next;
            error_seen_reg <= error_seen_next;
        end
    end

endmodule

// ===== design/expression_tokenizer.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// src     | in        | src_valid/src_stall | etk_pkg::src_item_t
// tok     | out       | tok_valid/tok_stall | etk_pkg::tok_item_t
//
// One source byte is taken per cycle while src_stall is low; it is
// classified against the hold register in the same cycle and its results
// (0, 1 or 2) written to a QUEUE_DEPTH-entry result queue. A byte giving
// two results leaves as two tok transfers. src_stall is high only while
// the queue is full. Reset clears the hold state and empties the queue.

module expression_tokenizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  etk_pkg::src_item_t src_data,
    output logic               tok_valid,
    input  logic               tok_stall,
    output etk_pkg::tok_item_t tok_data
);
    import etk_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    tok_pair_t        queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             sel_reg;
    logic             sel_next;

    logic             take;
    logic             push;
    logic             pop_out;
    logic             head_done;
    tok_pair_t        pair;
    tok_pair_t        head;

    etk_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (src_data),
        .pair  (pair)
    );

    assign src_stall = (count_reg == CNT_FULL);
    assign take      = src_valid && !src_stall;
    assign push      = take && (pair.count != 2'd0);

    assign head      = queue_mem[rd_ptr_reg];
    assign tok_valid = (count_reg != '0);
    assign tok_data  = sel_reg ? head.second : head.first;
    assign pop_out   = tok_valid && !tok_stall;
    assign head_done = pop_out && (sel_reg || (head.count != 2'd2));

    always_comb
    begin
        count_next = count_reg;
        if (push && !head_done)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && head_done)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        sel_next = sel_reg;
        if (head_done)
        begin
            sel_next = 1'b0;
        end
        else if (pop_out)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sel_reg   <= sel_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (head_done)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ===== design/etk_checker.sv =====
`timescale 1ns / 1ps

module etk_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               src_valid,
    input logic               src_stall,
    input etk_pkg::src_item_t src_data,
    input logic               tok_valid,
    input logic               tok_stall,
    input etk_pkg::tok_item_t tok_data
);
    import etk_pkg::*;

    // a stalled source transaction is held as it was offered
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("src transaction changed while stalled");

    // handshake rules on the result side
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid)
        else $error("tok_valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> $stable(tok_data))
        else $error("tok_data changed while stalled");

    // the rest of a transaction's results follow without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && !tok_data.run_last |=> tok_valid)
        else $error("second result of a transaction not ready");

    // only a flushed held character can precede another result
    a_first_held: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_data.run_last |->
            (tok_data.token_kind == KIND_IDENT) || (tok_data.token_kind == KIND_NUMBER))
        else $error("non-held token not last of its transaction");

endmodule

bind expression_tokenizer etk_checker u_etk_checker (.*);

// ===== verif/tb_expression_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_expression_tokenizer;

    import etk_pkg::*;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [7:0] SINGLES [10] = '{CH_ASSIGN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                            CH_LPAREN, CH_RPAREN, CH_COMMA, CH_LBRACE,
                                            CH_RBRACE};
    localparam logic [7:0] SPACES [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    localparam int LIVE_ITEMS = 2000;
    localparam int IDLE_PERCENT = 37;

    class token_scoreboard;
        tok_item_t  pending_tokens[$];
        tok_item_t  step_tokens[$];
        logic [7:0] held_char;
        hold_t      held_kind;
        bit         in_error;
        int         errors;
        int         live_items;

        function new();
            held_char  = '0;
            held_kind  = HOLD_NONE;
            in_error   = 1'b0;
            errors     = 0;
            live_items = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void emit(kind_t kind, logic [7:0] ch, logic last);
            tok_item_t t;
            t.token_kind = kind;
            t.token_char = ch;
            t.token_last = last;
            t.run_last   = 1'b0;
            step_tokens = {step_tokens, t};
        endfunction

        function void emit_held(logic last);
            if (held_kind == HOLD_IDENT)
                emit(KIND_IDENT, held_char, last);
            else if (held_kind == HOLD_NUMBER)
                emit(KIND_NUMBER, held_char, last);
        endfunction

        function void note_source(src_item_t s);
            logic [7:0] c;
            bit         letter;
            bit         digit;
            bit         space;
            bit         known;
            kind_t      single;
            c      = s.character;
            letter = (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
            digit  = c >= CH_ZERO && c <= CH_NINE;
            space  = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
            if (s.end_of_input || !in_error)
                live_items++;
            step_tokens.delete();
            if (s.end_of_input) begin
                if (!in_error)
                    emit_held(1'b1);
                emit(KIND_END, 8'h00, 1'b1);
                held_char = '0;
                held_kind = HOLD_NONE;
                in_error  = 1'b0;
            end else if (in_error) begin
                // dropped until end of input
            end else if (space) begin
                emit_held(1'b1);
                held_kind = HOLD_NONE;
            end else if (letter) begin
                emit_held(held_kind != HOLD_IDENT);
                held_char = c;
                held_kind = HOLD_IDENT;
            end else if (digit) begin
                if (held_kind == HOLD_IDENT || held_kind == HOLD_NUMBER)
                    emit_held(1'b0);
                else
                    held_kind = HOLD_NUMBER;
                held_char = c;
            end else begin
                known  = 1'b1;
                single = KIND_ERROR;
                case (c)
                    CH_ASSIGN: single = KIND_ASSIGN;
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: single = KIND_OPER;
                    CH_LPAREN: single = KIND_LPAREN;
                    CH_RPAREN: single = KIND_RPAREN;
                    CH_COMMA:  single = KIND_COMMA;
                    CH_LBRACE: single = KIND_LBRACE;
                    CH_RBRACE: single = KIND_RBRACE;
                    default:   known = 1'b0;
                endcase
                if (known) begin
                    emit_held(1'b1);
                    emit(single, c, 1'b1);
                end else begin
                    emit(KIND_ERROR, c, 1'b1);
                    in_error = 1'b1;
                end
                held_kind = HOLD_NONE;
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].run_last = 1'b1;
            foreach (step_tokens[i])
                pending_tokens = {pending_tokens, step_tokens[i]};
        endfunction

        task check_token(tok_item_t got);
            tok_item_t want;
            if (pending_tokens.size() == 0) begin
                report($sformatf("unexpected token kind %0d char %02h",
                                 got.token_kind, got.token_char));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
            if (got.token_char !== want.token_char)
                report($sformatf("token_char %02h, want %02h", got.token_char, want.token_char));
            if (got.token_last !== want.token_last)
                report($sformatf("token_last %0b, want %0b", got.token_last, want.token_last));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_data = '0;
    logic       tok_valid;
    logic       tok_stall = 1'b0;
    tok_item_t  tok_data;
    bit         steady = 1'b0;

    token_scoreboard sb;

    expression_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    always @(negedge clk)
    begin
        tok_stall <= idle_roll();
    end

    always @(posedge clk)
    begin
        if (rst_n && src_valid && !src_stall)
            sb.note_source(src_data);
        if (rst_n && tok_valid && !tok_stall)
            sb.check_token(tok_data);
    end

    // called and returns at a falling edge
    task automatic send(src_item_t item);
        while (idle_roll()) begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= item;
        do
            @(posedge clk);
        while (src_stall);
        @(negedge clk);
    endtask

    task automatic send_char(logic [7:0] c);
        src_item_t item;
        item.character    = c;
        item.end_of_input = 1'b0;
        send(item);
    endtask

    task automatic send_end();
        src_item_t item;
        item.character    = 8'($urandom_range(255));
        item.end_of_input = 1'b1;
        send(item);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? CH_LOWER_A + 8'(r) : CH_UPPER_A + 8'(r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic send_expression();
        int n_tok;
        int r;
        int len;
        n_tok = $urandom_range(12, 1);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_char(8'($urandom_range(255)));
            end else if (r < 28) begin
                len = $urandom_range(5, 1);
                send_char(rand_letter());
                for (int i = 1; i < len; i++)
                    send_char($urandom_range(2) == 0 ? rand_digit() : rand_letter());
            end else if (r < 48) begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    send_char(rand_digit());
            end else if (r < 78) begin
                send_char(SINGLES[$urandom_range(9)]);
            end else begin
                send_char(SPACES[$urandom_range(5)]);
            end
        end
        send_end();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_char(CH_LOWER_A);
        send_char(CH_UPPER_Z);
        send_char(CH_NINE);
        send_char(CH_SPACE);
        send_char(CH_ZERO);
        send_char(CH_NINE);
        send_char(CH_LOWER_Z);
        send_char(CH_TAB);
        send_char(CH_CR);
        foreach (SINGLES[i])
            send_char(SINGLES[i]);
        send_char(CH_ZERO + 8'd5);
        send_char(8'hFF);
        send_char(CH_LOWER_A + 8'd23);
        send_end();
        send_char(CH_UPPER_A);
        send_end();
        send_end();
        send_char(8'h00);
        send_end();

        while (sb.live_items < LIVE_ITEMS) begin
            steady = sb.live_items >= 800 && sb.live_items < 1100;
            send_expression();
        end
        steady = 1'b0;
        src_valid <= 1'b0;

        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/etk_pkg.sv
design/etk_lexer.sv
design/expression_tokenizer.sv
design/etk_checker.sv
verif/tb_expression_tokenizer.sv
